@@ rtl/i2c_register_access_master_top_defines.svh @@
// Assertion helpers used by the top-level RTL; clk and rst come from the using scope
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// same-cycle implication
`define I2CRAM_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define I2CRAM_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/i2cram_pkg.sv @@
`timescale 1ns / 1ps
package i2cram_pkg;

  localparam int RES_MAX = 3;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FREAD  = 3'd3;
  localparam logic [2:0] OP_FWRITE = 3'd4;
  localparam logic [2:0] OP_EVENT  = 3'd5;
  localparam logic [2:0] OP_TICK   = 3'd6;

  localparam logic [1:0] K_ACTION = 2'd0;
  localparam logic [1:0] K_RXBYTE = 2'd1;
  localparam logic [1:0] K_DONE   = 2'd2;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_TX    = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_NACK  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  localparam logic [3:0] E_OK          = 4'd0;
  localparam logic [3:0] E_TO_START    = 4'd1;
  localparam logic [3:0] E_TO_RESTART  = 4'd2;
  localparam logic [3:0] E_TO_ADDR     = 4'd3;
  localparam logic [3:0] E_TO_TXDATA   = 4'd4;
  localparam logic [3:0] E_TO_RXDATA   = 4'd5;
  localparam logic [3:0] E_ST_START    = 4'd6;
  localparam logic [3:0] E_ST_RESTART  = 4'd7;
  localparam logic [3:0] E_ST_ADDR     = 4'd8;
  localparam logic [3:0] E_ST_TXDATA   = 4'd9;
  localparam logic [3:0] E_ST_RXACK    = 4'd10;
  localparam logic [3:0] E_ST_RXNACK   = 4'd11;
  localparam logic [3:0] E_BAD_FIELD   = 4'd12;

  localparam logic [7:0] ST_MASK     = 8'hF8;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RESTART  = 8'h10;
  localparam logic [7:0] ST_ADDR_W   = 8'h18;
  localparam logic [7:0] ST_DATA_TX  = 8'h28;
  localparam logic [7:0] ST_ADDR_R   = 8'h40;
  localparam logic [7:0] ST_RX_ACK   = 8'h50;
  localparam logic [7:0] ST_RX_NACK  = 8'h58;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic [7:0] rx_data;
    logic [3:0] byte_index;
    logic [3:0] error_code;
    logic       last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] k, logic [2:0] a, logic [7:0] tx,
                                  logic [7:0] rx, logic [3:0] idx, logic [3:0] err);
    res_t r;
    r.kind       = k;
    r.bus_action = a;
    r.tx_byte    = tx;
    r.rx_data    = rx;
    r.byte_index = idx;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/i2cram_out_queue.sv @@
`timescale 1ns / 1ps
module i2cram_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_n,
  input  i2cram_pkg::res_t [2:0]        push_res,
  input  logic                          pop,
  output logic                          valid,
  output i2cram_pkg::res_t              head,
  output logic [2:0]                    count
);
  import i2cram_pkg::*;

  res_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;

  assign valid = count != 3'd0;
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (2'(k) < push_n) begin
        mem[wp + 2'(k)] <= push_res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

@@ rtl/i2c_register_access_master_top.sv @@
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------------
// input     | in_valid / in_stall       | op device_id reg_addr length bit_position
//           |                           | data_byte buf_index bus_status
// result    | out_valid / out_stall     | kind bus_action tx_byte rx_data byte_index
//           |                           | error_code last
// config    | cfg_write_en              | cfg_write_data (timeout_ticks)
//
// An input word is decoded in the cycle it is taken; its zero to three result words land in
// a four-entry result queue and leave one per cycle. Input is taken every cycle while the
// queue holds at most one word, so the rate is one word per cycle unless results back up.
// rst is synchronous; it returns the sequencer to idle and timeout_ticks to 5000.
// out_stall only holds the queue; in_stall rises once the queue cannot take three words.
module i2c_register_access_master_top #(
  parameter int MAX_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [6:0]  device_id,
  input  logic [7:0]  reg_addr,
  input  logic [4:0]  length,
  input  logic [2:0]  bit_position,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  buf_index,
  input  logic [7:0]  bus_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  bus_action,
  output logic [7:0]  tx_byte,
  output logic [7:0]  rx_data,
  output logic [3:0]  byte_index,
  output logic [3:0]  error_code,
  output logic        last,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);
  import i2cram_pkg::*;
`include "i2c_register_access_master_top_defines.svh"

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_W_START, PH_W_ADDR, PH_W_REG, PH_W_DATA, PH_R_RESTART,
    PH_R_ADDR, PH_R_DATA, PH_B_START, PH_B_ADDR, PH_B_REG, PH_B_DATA
  } phase_t;

  typedef enum logic [1:0] {OPK_WRITE, OPK_READ, OPK_FREAD, OPK_FWRITE} opk_t;

  phase_t      phase, phase_next;
  logic [6:0]  target_device, target_device_next;
  logic [7:0]  target_register, target_register_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [CW-1:0] byte_position, byte_position_next;
  opk_t        operation_kind, operation_kind_next;
  logic [2:0]  field_top_bit, field_top_bit_next;
  logic [3:0]  field_width, field_width_next;
  logic [7:0]  field_value, field_value_next;
  logic [15:0] wait_counter, wait_counter_next;
  logic [15:0] timeout_ticks;

  logic [7:0]  write_buffer [MAX_BYTES];
  logic [7:0]  rd_data;
  logic [AW-1:0] rd_addr;
  logic        load_we;

  res_t [2:0]  res_v;
  logic [1:0]  res_n;
  logic [2:0]  q_count;
  res_t        q_head;
  logic        accept;

  logic [7:0]  st;
  logic [3:0]  f_shift;
  logic [7:0]  f_mask;
  logic        lastb;
  logic [CW:0] pos_inc;
  logic [3:0]  to_code;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_count > 3'd1;
  assign st       = bus_status & ST_MASK;
  assign f_shift  = {1'b0, field_top_bit} + 4'd1 - field_width;
  assign f_mask   = 8'((9'((9'd1 << field_width) - 9'd1)) << f_shift);
  assign pos_inc  = {1'b0, byte_position} + (CW+1)'(1);
  assign lastb    = pos_inc >= {1'b0, byte_count};
  assign load_we  = accept && op == OP_LOAD && 32'(buf_index) < MAX_BYTES;

  always_comb begin
    case (phase)
      PH_W_START, PH_B_START:           to_code = E_TO_START;
      PH_R_RESTART:                     to_code = E_TO_RESTART;
      PH_W_ADDR, PH_B_ADDR, PH_R_ADDR:  to_code = E_TO_ADDR;
      PH_R_DATA:                        to_code = E_TO_RXDATA;
      default:                          to_code = E_TO_TXDATA;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    target_device_next   = target_device;
    target_register_next = target_register;
    byte_count_next      = byte_count;
    byte_position_next   = byte_position;
    operation_kind_next  = operation_kind;
    field_top_bit_next   = field_top_bit;
    field_width_next     = field_width;
    field_value_next     = field_value;
    wait_counter_next    = wait_counter;
    res_v = '0;
    res_n = 2'd0;

    if (accept) begin
      case (op)
        OP_WRITE, OP_READ, OP_FREAD, OP_FWRITE: begin
          if (phase == PH_IDLE) begin
            if ((op == OP_FREAD || op == OP_FWRITE) &&
                length > ({2'b00, bit_position} + 5'd1)) begin
              res_v[0] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_BAD_FIELD);
              res_n = 2'd1;
            end else begin
              target_device_next   = device_id;
              target_register_next = reg_addr;
              operation_kind_next  = opk_t'(2'(op - OP_WRITE));
              if (op == OP_WRITE) begin
                byte_count_next = (32'(length) > MAX_BYTES) ? CW'(MAX_BYTES) : CW'(length);
              end else if (op == OP_READ) begin
                if (length == 5'd0) byte_count_next = CW'(1);
                else byte_count_next = (32'(length) > MAX_BYTES) ? CW'(MAX_BYTES)
                                                                 : CW'(length);
              end else begin
                byte_count_next    = CW'(1);
                field_top_bit_next = bit_position;
                field_width_next   = 4'(length);
                field_value_next   = data_byte;
              end
              byte_position_next = '0;
              res_v[0] = mk_res(K_ACTION, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
              res_n = 2'd1;
              wait_counter_next = '0;
              phase_next = PH_W_START;
            end
          end
        end
        OP_EVENT: begin
          case (phase)
            PH_W_START, PH_B_START: begin
              if (st != ST_START) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_START);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                res_v[0] = mk_res(K_ACTION, ACT_TX, {target_device, 1'b0}, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = (phase == PH_B_START) ? PH_B_ADDR : PH_W_ADDR;
              end
            end
            PH_W_ADDR, PH_B_ADDR: begin
              if (st != ST_ADDR_W) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_ADDR);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                res_v[0] = mk_res(K_ACTION, ACT_TX, target_register, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = (phase == PH_B_ADDR) ? PH_B_REG : PH_W_REG;
              end
            end
            PH_W_REG: begin
              if (st != ST_DATA_TX) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_TXDATA);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else if (operation_kind == OPK_WRITE) begin
                if (byte_count == '0) begin
                  res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                  res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
                  res_n = 2'd2; phase_next = PH_IDLE;
                end else begin
                  // rd_data holds slot 0 here
                  byte_position_next = '0;
                  res_v[0] = mk_res(K_ACTION, ACT_TX, rd_data, 8'd0, 4'd0, E_OK);
                  res_n = 2'd1; wait_counter_next = '0;
                  phase_next = PH_W_DATA;
                end
              end else begin
                res_v[0] = mk_res(K_ACTION, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = PH_R_RESTART;
              end
            end
            PH_W_DATA: begin
              if (st != ST_DATA_TX) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_TXDATA);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                byte_position_next = CW'(pos_inc);
                if (pos_inc < {1'b0, byte_count}) begin
                  // rd_data is prefetched from the next slot
                  res_v[0] = mk_res(K_ACTION, ACT_TX, rd_data, 8'd0, 4'd0, E_OK);
                  res_n = 2'd1; wait_counter_next = '0;
                end else begin
                  res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                  res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
                  res_n = 2'd2; phase_next = PH_IDLE;
                end
              end
            end
            PH_B_REG: begin
              if (st != ST_DATA_TX) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_TXDATA);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                res_v[0] = mk_res(K_ACTION, ACT_TX, field_value, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = PH_B_DATA;
              end
            end
            PH_B_DATA: begin
              res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
              res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0,
                                (st != ST_DATA_TX) ? E_ST_TXDATA : E_OK);
              res_n = 2'd2; phase_next = PH_IDLE;
            end
            PH_R_RESTART: begin
              if (st != ST_RESTART) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_RESTART);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                res_v[0] = mk_res(K_ACTION, ACT_TX, {target_device, 1'b1}, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = PH_R_ADDR;
              end
            end
            PH_R_ADDR: begin
              if (st != ST_ADDR_R) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_ST_ADDR);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                byte_position_next = '0;
                res_v[0] = mk_res(K_ACTION, (byte_count > CW'(1)) ? ACT_ACK : ACT_NACK,
                                  8'd0, 8'd0, 4'd0, E_OK);
                res_n = 2'd1; wait_counter_next = '0;
                phase_next = PH_R_DATA;
              end
            end
            PH_R_DATA: begin
              if (st != (lastb ? ST_RX_NACK : ST_RX_ACK)) begin
                res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0,
                                  lastb ? E_ST_RXNACK : E_ST_RXACK);
                res_n = 2'd2; phase_next = PH_IDLE;
              end else begin
                if (operation_kind == OPK_READ) begin
                  res_v[0] = mk_res(K_RXBYTE, ACT_START, 8'd0, data_byte,
                                    4'(byte_position), E_OK);
                  res_n = 2'd1;
                end
                if (!lastb) begin
                  byte_position_next = CW'(pos_inc);
                  res_v[res_n] = mk_res(K_ACTION,
                      ((pos_inc + (CW+1)'(1)) < {1'b0, byte_count}) ? ACT_ACK : ACT_NACK,
                      8'd0, 8'd0, 4'd0, E_OK);
                  res_n = res_n + 2'd1; wait_counter_next = '0;
                end else if (operation_kind == OPK_FREAD) begin
                  res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                  res_v[1] = mk_res(K_DONE, ACT_START, 8'd0,
                                    8'((data_byte & f_mask) >> f_shift), 4'd0, E_OK);
                  res_n = 2'd2; phase_next = PH_IDLE;
                end else if (operation_kind == OPK_FWRITE) begin
                  // merge the field and write the byte back in a new transaction
                  field_value_next = (data_byte & ~f_mask) |
                                     (8'({8'd0, field_value} << f_shift) & f_mask);
                  res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                  res_v[1] = mk_res(K_ACTION, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
                  res_n = 2'd2; wait_counter_next = '0;
                  phase_next = PH_B_START;
                end else begin
                  res_v[res_n] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
                  res_v[res_n + 2'd1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, E_OK);
                  res_n = res_n + 2'd2; phase_next = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (wait_counter >= timeout_ticks) begin
              res_v[0] = mk_res(K_ACTION, ACT_STOP, 8'd0, 8'd0, 4'd0, E_OK);
              res_v[1] = mk_res(K_DONE, ACT_START, 8'd0, 8'd0, 4'd0, to_code);
              res_n = 2'd2; phase_next = PH_IDLE;
            end else begin
              wait_counter_next = wait_counter + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
    if (res_n != 2'd0) res_v[res_n - 2'd1].last = 1'b1;
  end

  // prefetch the buffer slot the next transmit will need
  always_comb begin
    if (phase_next == PH_W_DATA) rd_addr = AW'(byte_position_next + CW'(1));
    else rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (load_we) write_buffer[AW'(buf_index)] <= data_byte;
    if (load_we && AW'(buf_index) == rd_addr) rd_data <= data_byte;
    else rd_data <= write_buffer[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      target_device   <= '0;
      target_register <= '0;
      byte_count      <= '0;
      byte_position   <= '0;
      operation_kind  <= OPK_WRITE;
      field_top_bit   <= '0;
      field_width     <= '0;
      field_value     <= '0;
      wait_counter    <= '0;
      timeout_ticks   <= TIMEOUT_RESET;
    end else begin
      phase           <= phase_next;
      target_device   <= target_device_next;
      target_register <= target_register_next;
      byte_count      <= byte_count_next;
      byte_position   <= byte_position_next;
      operation_kind  <= operation_kind_next;
      field_top_bit   <= field_top_bit_next;
      field_width     <= field_width_next;
      field_value     <= field_value_next;
      wait_counter    <= wait_counter_next;
      if (cfg_write_en) timeout_ticks <= cfg_write_data;
    end
  end

  i2cram_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_n   (res_n),
    .push_res (res_v),
    .pop      (out_valid && !out_stall),
    .valid    (out_valid),
    .head     (q_head),
    .count    (q_count)
  );

  assign kind       = q_head.kind;
  assign bus_action = q_head.bus_action;
  assign tx_byte    = q_head.tx_byte;
  assign rx_data    = q_head.rx_data;
  assign byte_index = q_head.byte_index;
  assign error_code = q_head.error_code;
  assign last       = q_head.last;

  `I2CRAM_ASSERT_IMP(a_done_last, out_valid && kind == K_DONE, last, "completion word not last")
  `I2CRAM_ASSERT_IMP(a_rise_accept, $rose(out_valid), $past(accept), "result without input")
  `I2CRAM_ASSERT_NXT(a_push_valid, res_n != 2'd0, out_valid, "pushed word not presented")

endmodule
